>>> hdl/bsa_pkg.sv
// Shared constants, codes and helpers for the bilinear screen accumulator.
package bsa_pkg;

    localparam int DEF_SCREEN_W    = 64;
    localparam int DEF_SCREEN_H    = 64;
    localparam int DEF_MAX_SCREENS = 4;
    localparam int DEF_OUT_W       = 32;
    localparam int DEF_OUT_H       = 32;

    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_AW      = 2;
    localparam int CFG_DW      = 7;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ACC    = 2'd1;
    localparam logic [1:0] OP_PRESET = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    localparam logic [CFG_AW-1:0] CFG_SCREEN_W     = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_SCREEN_H     = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_SCREEN_COUNT = 2'd2;

    localparam logic [6:0] RST_SCREEN_W     = 7'd64;
    localparam logic [6:0] RST_SCREEN_H     = 7'd64;
    localparam logic [2:0] RST_SCREEN_COUNT = 3'd1;

    function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
        logic signed [15:0] r;
        if (v > 24'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -24'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

>>> hdl/bsa_bank.sv
// Screen store bank: one write port and two registered read ports.
module bsa_bank #(
    parameter int DEPTH = 8192
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic signed [15:0]               i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr_b,
    output logic signed [15:0]               o_rdata_a,
    output logic signed [15:0]               o_rdata_b
);

    logic signed [15:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rdata_a <= mem[i_raddr_a];
            o_rdata_b <= mem[i_raddr_b];
        end
    end

endmodule

>>> hdl/bsa_pix_ram.sv
// Accumulator image memory: one write port and one registered read port.
module bsa_pix_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic                    i_we,
    input  logic [AW-1:0]           i_waddr,
    input  logic signed [23:0]      i_wdata,
    input  logic [AW-1:0]           i_raddr,
    output logic signed [23:0]      o_rdata
);

    logic signed [23:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

>>> hdl/bilinear_screen_accumulate.sv
// Top level: bilinear screen sampling into a saturating accumulator image.
// An accepted item passes through the pipeline stage registers and then the output register before its result is valid.
// Throughput: one item per cycle while the output is not stalled; two parity banks give all four corners at once.
// The accumulator pixel is forwarded from the write-back stage to items in flight.
// Reset clears the pipeline valid bits and sets the registers to 64, 64 and 1.
// Neither memory is cleared; entries are undefined until written.
module bilinear_screen_accumulate #(
    parameter int SCREEN_W    = bsa_pkg::DEF_SCREEN_W,
    parameter int SCREEN_H    = bsa_pkg::DEF_SCREEN_H,
    parameter int MAX_SCREENS = bsa_pkg::DEF_MAX_SCREENS,
    parameter int OUT_W       = bsa_pkg::DEF_OUT_W,
    parameter int OUT_H       = bsa_pkg::DEF_OUT_H
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bsa_pkg::CFG_AW-1:0]       i_cfg_addr,
    input  logic [bsa_pkg::CFG_DW-1:0]       i_cfg_wdata,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // screen, sample_x, sample_y, out_x, out_y, int_shift_x, int_shift_y,
    // frac_x, frac_y, value, zero pad
    input  logic [bsa_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // operation
    input  logic [1:0]                       i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // pixel_value
    output logic [bsa_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // status
    output logic [1:0]                       o_m_axis_tuser
);
    import bsa_pkg::*;

    localparam int STORE_D = SCREEN_W * SCREEN_H * MAX_SCREENS;
    localparam int SAW     = $clog2(STORE_D);
    localparam int CW      = ((SAW > 17) ? SAW : 17) + 1;
    localparam int BD      = (STORE_D + 1) / 2;
    localparam int BAW     = $clog2(BD);
    localparam int IMG_D   = OUT_W * OUT_H;
    localparam int PAW     = (IMG_D > 1) ? $clog2(IMG_D) : 1;
    localparam int RST_WHC = 64 * 64 * 1;
    localparam int RST_LIM = (RST_WHC < STORE_D) ? RST_WHC : STORE_D;

    typedef struct packed {
        logic [1:0]          op;
        logic                ok;
        logic                pok;
        logic [PAW-1:0]      paddr;
        logic signed [23:0]  val;
    } t_meta;

    // Configuration and derived terms.
    logic [6:0]    r_w, r_h, n_w, n_h;
    logic [2:0]    r_cnt, n_cnt;
    logic [13:0]   r_wh, n_wh;
    logic [CW-1:0] r_lim, n_lim;
    logic [16:0]   n_whc;

    always_comb begin
        n_w   = r_w;
        n_h   = r_h;
        n_cnt = r_cnt;
        if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SCREEN_W:     n_w   = i_cfg_wdata[6:0];
                CFG_SCREEN_H:     n_h   = i_cfg_wdata[6:0];
                CFG_SCREEN_COUNT: n_cnt = i_cfg_wdata[2:0];
                default:          n_w   = r_w;
            endcase
        end
        n_wh  = n_w * n_h;
        n_whc = n_wh * n_cnt;
        n_lim = (CW'(n_whc) < CW'(STORE_D)) ? CW'(n_whc) : CW'(STORE_D);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w   <= RST_SCREEN_W;
            r_h   <= RST_SCREEN_H;
            r_cnt <= RST_SCREEN_COUNT;
            r_wh  <= 14'(64 * 64);
            r_lim <= CW'(RST_LIM);
        end else begin
            r_w   <= n_w;
            r_h   <= n_h;
            r_cnt <= n_cnt;
            r_wh  <= n_wh;
            r_lim <= n_lim;
        end
    end

    // Input fields.
    logic [1:0]         in_op, in_scr;
    logic [5:0]         in_sx, in_sy, in_ix, in_iy;
    logic [4:0]         in_ox, in_oy;
    logic [15:0]        in_fx, in_fy;
    logic signed [23:0] in_val;

    assign in_op  = i_s_axis_tuser;
    assign in_scr = i_s_axis_tdata[1:0];
    assign in_sx  = i_s_axis_tdata[7:2];
    assign in_sy  = i_s_axis_tdata[13:8];
    assign in_ox  = i_s_axis_tdata[18:14];
    assign in_oy  = i_s_axis_tdata[23:19];
    assign in_ix  = i_s_axis_tdata[29:24];
    assign in_iy  = i_s_axis_tdata[35:30];
    assign in_fx  = i_s_axis_tdata[51:36];
    assign in_fy  = i_s_axis_tdata[67:52];
    assign in_val = i_s_axis_tdata[91:68];

    // Pipeline control.
    logic r_v1, r_v2, r_v3, r_v4, r_ovalid;
    logic en, fire;

    assign en              = !r_ovalid || i_m_axis_tready;
    assign fire            = i_s_axis_tvalid && en;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_ovalid;

    // Address generation.
    logic [CW-1:0]      la, base, bw, far, te, to, be, bo;
    logic               load_ok, corner_ok;
    logic signed [15:0] ld_sample;
    t_meta              m0;

    always_comb begin
        la        = in_scr * r_wh + in_sy * r_w + in_sx;
        base      = in_scr * r_wh + in_iy * r_w + in_ix;
        bw        = base + r_w;
        far       = bw + CW'(1);
        te        = base[0] ? base + CW'(1) : base;
        to        = base[0] ? base : base + CW'(1);
        be        = bw[0] ? bw + CW'(1) : bw;
        bo        = bw[0] ? bw : bw + CW'(1);
        load_ok   = (in_sx < r_w) && (in_sy < r_h) && (in_scr < r_cnt)
                    && (la < CW'(STORE_D));
        corner_ok = far < r_lim;
        ld_sample = sat16(in_val);
        m0.op     = in_op;
        m0.ok     = (in_op == OP_LOAD) ? load_ok : corner_ok;
        m0.pok    = (32'(in_ox) < OUT_W) && (32'(in_oy) < OUT_H);
        m0.paddr  = PAW'(32'(in_oy) * OUT_W + 32'(in_ox));
        m0.val    = (in_op == OP_LOAD) ? {{8{ld_sample[15]}}, ld_sample} : in_val;
    end

    logic ld_we;
    assign ld_we = fire && (in_op == OP_LOAD) && load_ok;

    logic signed [15:0] ev_a, ev_b, od_a, od_b;

    bsa_bank #(.DEPTH(BD)) u_bank_even (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_we      (ld_we && !la[0]),
        .i_waddr   (la[BAW:1]),
        .i_wdata   (ld_sample),
        .i_raddr_a (te[BAW:1]),
        .i_raddr_b (be[BAW:1]),
        .o_rdata_a (ev_a),
        .o_rdata_b (ev_b)
    );

    bsa_bank #(.DEPTH(BD)) u_bank_odd (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_we      (ld_we && la[0]),
        .i_waddr   (la[BAW:1]),
        .i_wdata   (ld_sample),
        .i_raddr_a (to[BAW:1]),
        .i_raddr_b (bo[BAW:1]),
        .o_rdata_a (od_a),
        .o_rdata_b (od_b)
    );

    // Accumulator write-back and forwarding.
    t_meta              r_m1, r_m2, r_m3, r_m4;
    logic               wr_en;
    logic signed [23:0] wr_val, pix_rd, pix1, sat_sum;
    logic signed [24:0] sum;
    logic signed [23:0] r_pix2, r_pix3, r_pix4, r_fwdv;
    logic               r_fwd1;

    bsa_pix_ram #(.DEPTH(IMG_D), .AW(PAW)) u_pix_ram (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_we    (wr_en),
        .i_waddr (r_m4.paddr),
        .i_wdata (wr_val),
        .i_raddr (m0.paddr),
        .o_rdata (pix_rd)
    );

    assign pix1 = r_fwd1 ? r_fwdv : pix_rd;

    // Interpolation datapath.
    logic               r_pt, r_pb;
    logic [15:0]        r_fx1, r_fy1, r_fy2;
    logic signed [15:0] s0, s1, s2, s3;
    logic signed [16:0] fxs, fys, dtop, dbot;
    logic signed [33:0] mtop, mbot, n_top, n_bot, r_top2, r_bot2, r_top3, dvert;
    logic signed [49:0] n_prod, r_prod3, sacc, sbias;
    logic signed [17:0] r_r4;

    always_comb begin
        s0     = r_pt ? od_a : ev_a;
        s1     = r_pt ? ev_a : od_a;
        s2     = r_pb ? od_b : ev_b;
        s3     = r_pb ? ev_b : od_b;
        fxs    = $signed({1'b0, r_fx1});
        dtop   = s1 - s0;
        dbot   = s3 - s2;
        mtop   = fxs * dtop;
        mbot   = fxs * dbot;
        n_top  = $signed({{2{s0[15]}}, s0, 16'b0}) + mtop;
        n_bot  = $signed({{2{s2[15]}}, s2, 16'b0}) + mbot;
        fys    = $signed({1'b0, r_fy2});
        dvert  = r_bot2 - r_top2;
        n_prod = fys * dvert;
        sacc   = $signed({r_top3, 16'b0}) + r_prod3;
        sbias  = sacc + 50'sd2147483648;
    end

    always_comb begin
        sum = r_pix4 + r_r4;
        if (sum > 25'sd8388607) begin
            sat_sum = 24'sh7FFFFF;
        end else if (sum < -25'sd8388608) begin
            sat_sum = 24'sh800000;
        end else begin
            sat_sum = sum[23:0];
        end
        wr_en  = en && r_v4 && r_m4.pok
                 && ((r_m4.op == OP_PRESET) || ((r_m4.op == OP_ACC) && r_m4.ok));
        wr_val = (r_m4.op == OP_PRESET) ? r_m4.val : sat_sum;
    end

    logic [1:0]         res_st;
    logic signed [23:0] res_pix;

    always_comb begin
        res_st  = ST_RANGE;
        res_pix = '0;
        if (r_m4.op == OP_LOAD) begin
            if (r_m4.ok) begin
                res_st  = ST_OK;
                res_pix = r_m4.val;
            end
        end else if (r_m4.pok) begin
            case (r_m4.op)
                OP_PRESET: begin
                    res_st  = ST_OK;
                    res_pix = r_m4.val;
                end
                OP_READ: begin
                    res_st  = ST_OK;
                    res_pix = r_pix4;
                end
                OP_ACC: begin
                    if (r_m4.ok) begin
                        res_st  = (sum != 25'(sat_sum)) ? ST_SAT : ST_OK;
                        res_pix = sat_sum;
                    end else begin
                        res_st  = ST_RANGE;
                        res_pix = r_pix4;
                    end
                end
                default: begin
                    res_st  = ST_RANGE;
                    res_pix = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
            r_ovalid <= 1'b0;
        end else if (en) begin
            r_v1     <= fire;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            r_v4     <= r_v3;
            r_ovalid <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1    <= m0;
            r_pt    <= base[0];
            r_pb    <= bw[0];
            r_fx1   <= in_fx;
            r_fy1   <= in_fy;
            r_fwd1  <= wr_en && (m0.paddr == r_m4.paddr);
            r_fwdv  <= wr_val;

            r_m2    <= r_m1;
            r_top2  <= n_top;
            r_bot2  <= n_bot;
            r_fy2   <= r_fy1;
            r_pix2  <= (wr_en && (r_m1.paddr == r_m4.paddr)) ? wr_val : pix1;

            r_m3    <= r_m2;
            r_top3  <= r_top2;
            r_prod3 <= n_prod;
            r_pix3  <= (wr_en && (r_m2.paddr == r_m4.paddr)) ? wr_val : r_pix2;

            r_m4    <= r_m3;
            r_r4    <= sbias[49:32];
            r_pix4  <= (wr_en && (r_m3.paddr == r_m4.paddr)) ? wr_val : r_pix3;

            o_m_axis_tuser <= res_st;
            o_m_axis_tdata <= res_pix;
        end
    end

endmodule
